// ===== hdl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce press classifier.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package bdpc_pkg;

    // widths of fields and registers
    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 16;
    localparam int unsigned EvW   = 2;

    // register reset values
    localparam logic [CfgW-1:0] DebounceTimeRst  = 16'd20;
    localparam logic [CfgW-1:0] LongPressTimeRst = 16'd1000;

    // register map, index taken from the word address
    localparam logic RegDebounceTime  = 1'b0;
    localparam logic RegLongPressTime = 1'b1;

    // debouncer phases, one-hot
    typedef enum logic [3:0] {
        PH_RELEASED    = 4'b0001,
        PH_DEB_PRESS   = 4'b0010,
        PH_PRESSED     = 4'b0100,
        PH_DEB_RELEASE = 4'b1000
    } phase_t;

    // event codes
    typedef enum logic [EvW-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // configuration handed from the register file to the classifier
    typedef struct packed {
        logic [CfgW-1:0] debounce_time;
        logic [CfgW-1:0] long_press_time;
    } cfg_t;

    // one classified sample
    typedef struct packed {
        event_t press_event;
        logic   busy_res;
    } result_t;

endpackage

// ===== hdl/bdpc_cfg_regs.sv =====
// APB-style configuration registers: debounce time and long-press time.
// Depends on bdpc_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module bdpc_cfg_regs
    import bdpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic            wr_en;
    logic            reg_sel;
    logic [CfgW-1:0] debounce_time_reg;
    logic [CfgW-1:0] long_press_time_reg;

    // word select, byte lanes ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg   <= DebounceTimeRst;
            long_press_time_reg <= LongPressTimeRst;
        end
        else if (wr_en)
        begin
            if (reg_sel == RegDebounceTime)
                debounce_time_reg <= pwdata[CfgW-1:0];
            else
                long_press_time_reg <= pwdata[CfgW-1:0];
        end
    end

    // read back
    always_comb
    begin
        if (reg_sel == RegDebounceTime)
            prdata = {{(32-CfgW){1'b0}}, debounce_time_reg};
        else
            prdata = {{(32-CfgW){1'b0}}, long_press_time_reg};
    end

    assign cfg.debounce_time   = debounce_time_reg;
    assign cfg.long_press_time = long_press_time_reg;

endmodule

// ===== hdl/bdpc_classifier.sv =====
// Debounce state machine and press classification for one sample per step.
// Depends on bdpc_pkg for phase_t, event_t, cfg_t and result_t.
`timescale 1ns / 1ps

module bdpc_classifier
    import bdpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             pin_pressed,
    input  logic [TimeW-1:0] now_ms,
    input  cfg_t             cfg,
    output result_t          result
);

    phase_t           phase_reg, phase_next;
    logic [TimeW-1:0] phase_entry_time_reg, phase_entry_time_next;
    logic [TimeW-1:0] press_start_time_reg, press_start_time_next;
    logic             long_fired_reg, long_fired_next;
    event_t           event_code;
    logic             debounce_done;
    logic             long_done;
    logic [TimeW-1:0] since_entry;
    logic [TimeW-1:0] since_press;

    // wrap-around elapsed times against the thresholds
    assign since_entry   = now_ms - phase_entry_time_reg;
    assign since_press   = now_ms - press_start_time_reg;
    assign debounce_done = since_entry >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time};
    assign long_done     = since_press >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_time};

    // next phase and event
    always_comb
    begin
        phase_next            = phase_reg;
        phase_entry_time_next = phase_entry_time_reg;
        press_start_time_next = press_start_time_reg;
        long_fired_next       = long_fired_reg;
        event_code            = EV_NONE;
        unique case (phase_reg)
            PH_RELEASED:
            begin
                if (pin_pressed)
                begin
                    phase_next            = PH_DEB_PRESS;
                    phase_entry_time_next = now_ms;
                end
            end
            PH_DEB_PRESS:
            begin
                if (!pin_pressed)
                    phase_next = PH_RELEASED;
                else if (debounce_done)
                begin
                    phase_next            = PH_PRESSED;
                    press_start_time_next = now_ms;
                    long_fired_next       = 1'b0;
                end
            end
            PH_PRESSED:
            begin
                if (!pin_pressed)
                begin
                    phase_next            = PH_DEB_RELEASE;
                    phase_entry_time_next = now_ms;
                end
                else if (!long_fired_reg && long_done)
                begin
                    long_fired_next = 1'b1;
                    event_code      = EV_LONG;
                end
            end
            PH_DEB_RELEASE:
            begin
                // bounce back keeps the hold start and long flag
                if (pin_pressed)
                    phase_next = PH_PRESSED;
                else if (debounce_done)
                begin
                    phase_next      = PH_RELEASED;
                    long_fired_next = 1'b0;
                    if (!long_fired_reg)
                        event_code = EV_SHORT;
                end
            end
            default:
            begin
                phase_next      = PH_RELEASED;
                long_fired_next = 1'b0;
            end
        endcase
    end

    assign result.press_event = event_code;
    assign result.busy_res    = (phase_next != PH_RELEASED) | pin_pressed;

    // state update on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_RELEASED;
            phase_entry_time_reg <= '0;
            press_start_time_reg <= '0;
            long_fired_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg            <= phase_next;
            phase_entry_time_reg <= phase_entry_time_next;
            press_start_time_reg <= press_start_time_next;
            long_fired_reg       <= long_fired_next;
        end
    end

    // long flag is always clear once released
    a_released_no_long: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RELEASED |-> !long_fired_reg)
        else $error("long flag set in released phase");

    // a long press leaves the button pressed with the flag set
    a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && event_code == EV_LONG |=> long_fired_reg && phase_reg == PH_PRESSED)
        else $error("long press did not latch");

    // a short press ends the hold
    a_short_releases: assert property (@(posedge clk) disable iff (!rst_n)
        step && event_code == EV_SHORT |=> phase_reg == PH_RELEASED)
        else $error("short press without release");

endmodule

// ===== hdl/button_debounce_press_classifier_unit.sv =====
// Top level of the button debounce press classifier: sample register,
// classifier and result register. Depends on bdpc_pkg, bdpc_cfg_regs, bdpc_classifier.
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  sample    in_valid/in_ready, pin_pressed, now_ms     in
//  result    out_valid/out_ready, press_event, busy_res  out
//  config    psel/penable/pwrite/paddr/pwdata/prdata    in/out
//
// One sample per cycle sustained while the result side is ready; a sample passes
// through the sample register and then the result register before it is offered.
// The classifier state advances as a sample moves into the result register.
// A stalled result blocks only once the sample register is also full.
// rst_n clears the phase to released, both times to zero and the registers
// to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module button_debounce_press_classifier_unit
    import bdpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             pin_pressed,
    input  logic [TimeW-1:0] now_ms,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [EvW-1:0]   press_event,
    output logic             busy_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t             cfg;
    result_t          result;
    logic             in_valid_reg;
    logic             pin_pressed_reg;
    logic [TimeW-1:0] now_ms_reg;
    logic             out_valid_reg;
    result_t          result_reg;
    logic             advance;

    bdpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: sample moves on when the result slot is free or drains
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            pin_pressed_reg <= pin_pressed;
            now_ms_reg      <= now_ms;
        end
    end

    bdpc_classifier u_classifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pin_pressed (pin_pressed_reg),
        .now_ms      (now_ms_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign press_event = result_reg.press_event;
    assign busy_res    = result_reg.busy_res;

    // a waiting result is never dropped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(result_reg))
        else $error("pending result lost");

    // an empty result slot never blocks the sample side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("sample stalled with free result slot");

    // no undefined event code leaves the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> press_event != 2'd3)
        else $error("invalid event code");

endmodule
